// ----- rtl/tle_pkg.sv -----
// shared types, byte codes and datapath commands of the terminal line editor
package tle_pkg;

  // default sizes
  localparam int unsigned LineSizeDef     = 64;
  localparam int unsigned HistoryDepthDef = 5;

  // terminal byte codes
  localparam logic [7:0] ByteCtrlA  = 8'd1;
  localparam logic [7:0] ByteCtrlC  = 8'd3;
  localparam logic [7:0] ByteCtrlD  = 8'd4;
  localparam logic [7:0] ByteCtrlE  = 8'd5;
  localparam logic [7:0] ByteEnter  = 8'd13;
  localparam logic [7:0] ByteEsc    = 8'd27;
  localparam logic [7:0] ByteCsi    = 8'd91;
  localparam logic [7:0] ByteSs3    = 8'd79;
  localparam logic [7:0] ByteUp     = 8'd65;
  localparam logic [7:0] ByteDown   = 8'd66;
  localparam logic [7:0] ByteRight  = 8'd67;
  localparam logic [7:0] ByteLeft   = 8'd68;
  localparam logic [7:0] ByteHome   = 8'd72;
  localparam logic [7:0] ByteEnd    = 8'd70;
  localparam logic [7:0] ByteDel    = 8'd127;
  localparam logic [7:0] BytePrtLo  = 8'd32;
  localparam logic [7:0] BytePrtHi  = 8'd126;

  // result kinds
  localparam logic [1:0] EvChar  = 2'd0;
  localparam logic [1:0] EvEmpty = 2'd1;
  localparam logic [1:0] EvAbort = 2'd2;

  // datapath command issued by the controller each cycle
  typedef enum logic [4:0] {
    OpNone,
    OpHome,
    OpEnd,
    OpRight,
    OpLeft,
    OpAbortOut,
    OpEmptyOut,
    OpInsStart,
    OpInsRd,
    OpInsWr,
    OpInsFin,
    OpDelStart,
    OpDelRd,
    OpDelWr,
    OpDelFin,
    OpEntStart,
    OpEntRd,
    OpEntOut,
    OpEntFin,
    OpOlder,
    OpNewer,
    OpNewerClr,
    OpLoadRd,
    OpLoadWr,
    OpLoadFin
  } dp_op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic len_zero;
    logic cur_zero;
    logic full;
    logic idx_gt_cur;
    logic idx_lt_len;
    logic idx_last;
    logic idx_lt_hlen;
    logic older_ok;
    logic recalled;
    logic pos_zero;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/tle_ctrl.sv -----
// controller: byte decoder, escape sequence tracking and editing sequencer
module tle_ctrl import tle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rx_valid_i,
  output logic     rx_stall_o,
  input  logic [7:0] rx_byte_i,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  typedef enum logic [3:0] {
    SIdle,
    SAbort,
    SEmpty,
    SInsChk,
    SInsWr,
    SDelChk,
    SDelWr,
    SEntRd,
    SEntOut,
    SEntFin,
    SLoadChk,
    SLoadWr
  } state_e;

  typedef enum logic [1:0] {
    EscIdle,
    EscSeen,
    EscCsi,
    EscSs3
  } esc_e;

  state_e state_q, state_d;
  esc_e   esc_q, esc_d;
  logic   accept;

  assign rx_stall_o = (state_q != SIdle);
  assign accept     = rx_valid_i && (state_q == SIdle);

  // next state and command
  always_comb begin
    state_d = state_q;
    esc_d   = esc_q;
    op_o    = OpNone;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          priority if (rx_byte_i == ByteCtrlC || rx_byte_i == ByteCtrlD) begin
            esc_d   = EscIdle;
            state_d = SAbort;
          end else if (rx_byte_i == ByteCtrlA) begin
            op_o = OpHome;
          end else if (rx_byte_i == ByteCtrlE) begin
            op_o = OpEnd;
          end else if (rx_byte_i == ByteDel) begin
            if (!stat_i.cur_zero) begin
              op_o    = OpDelStart;
              state_d = SDelChk;
            end
          end else if (rx_byte_i == ByteEsc) begin
            esc_d = EscSeen;
          end else if (esc_q != EscIdle) begin
            // byte belongs to the sequence
            esc_d = EscIdle;
            unique case (esc_q)
              EscSeen: begin
                if (rx_byte_i == ByteCsi) esc_d = EscCsi;
                else if (rx_byte_i == ByteSs3) esc_d = EscSs3;
              end
              EscCsi: begin
                priority if (rx_byte_i == ByteUp) begin
                  if (stat_i.older_ok) begin
                    op_o    = OpOlder;
                    state_d = SLoadChk;
                  end
                end else if (rx_byte_i == ByteDown) begin
                  if (stat_i.recalled) begin
                    if (stat_i.pos_zero) begin
                      op_o = OpNewerClr;
                    end else begin
                      op_o    = OpNewer;
                      state_d = SLoadChk;
                    end
                  end
                end else if (rx_byte_i == ByteRight) begin
                  op_o = OpRight;
                end else if (rx_byte_i == ByteLeft) begin
                  op_o = OpLeft;
                end else begin
                  op_o = OpNone;
                end
              end
              EscSs3: begin
                if (rx_byte_i == ByteHome) op_o = OpHome;
                else if (rx_byte_i == ByteEnd) op_o = OpEnd;
              end
              default: esc_d = EscIdle;
            endcase
          end else if (rx_byte_i == ByteEnter) begin
            if (stat_i.len_zero) begin
              state_d = SEmpty;
            end else begin
              op_o    = OpEntStart;
              state_d = SEntRd;
            end
          end else if (rx_byte_i >= BytePrtLo && rx_byte_i <= BytePrtHi) begin
            if (!stat_i.full) begin
              op_o    = OpInsStart;
              state_d = SInsChk;
            end
          end else begin
            op_o = OpNone;
          end
        end
      end
      SAbort: begin
        if (stat_i.out_free) begin
          op_o    = OpAbortOut;
          state_d = SIdle;
        end
      end
      SEmpty: begin
        if (stat_i.out_free) begin
          op_o    = OpEmptyOut;
          state_d = SIdle;
        end
      end
      // shift the tail up by one, top down
      SInsChk: begin
        if (stat_i.idx_gt_cur) begin
          op_o    = OpInsRd;
          state_d = SInsWr;
        end else begin
          op_o    = OpInsFin;
          state_d = SIdle;
        end
      end
      SInsWr: begin
        op_o    = OpInsWr;
        state_d = SInsChk;
      end
      // shift the tail down by one, bottom up
      SDelChk: begin
        if (stat_i.idx_lt_len) begin
          op_o    = OpDelRd;
          state_d = SDelWr;
        end else begin
          op_o    = OpDelFin;
          state_d = SIdle;
        end
      end
      SDelWr: begin
        op_o    = OpDelWr;
        state_d = SDelChk;
      end
      // send the line and copy it into history
      SEntRd: begin
        op_o    = OpEntRd;
        state_d = SEntOut;
      end
      SEntOut: begin
        if (stat_i.out_free) begin
          op_o    = OpEntOut;
          state_d = stat_i.idx_last ? SEntFin : SEntRd;
        end
      end
      SEntFin: begin
        op_o    = OpEntFin;
        state_d = SIdle;
      end
      // copy a history entry into the line
      SLoadChk: begin
        if (stat_i.idx_lt_hlen) begin
          op_o    = OpLoadRd;
          state_d = SLoadWr;
        end else begin
          op_o    = OpLoadFin;
          state_d = SIdle;
        end
      end
      SLoadWr: begin
        op_o    = OpLoadWr;
        state_d = SLoadChk;
      end
      default: state_d = SIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      esc_q   <= EscIdle;
    end else begin
      state_q <= state_d;
      esc_q   <= esc_d;
    end
  end

endmodule

// ----- rtl/tle_dp.sv -----
// datapath: line memory, history ring memory, cursor and result register
module tle_dp import tle_pkg::*; #(
  parameter int unsigned LINE_SIZE     = LineSizeDef,
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_op_e     op_i,
  input  logic [7:0] rx_byte_i,
  output dp_stat_t   stat_o,
  output logic       ev_valid_o,
  input  logic       ev_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] line_char_o,
  output logic       last_of_line_o
);

  localparam int unsigned LW       = $clog2(LINE_SIZE);
  localparam int unsigned HW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW       = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned AW       = $clog2(HISTORY_DEPTH * LINE_SIZE);
  localparam int unsigned LineCap  = (LINE_SIZE - 1 < 63) ? LINE_SIZE - 1 : 63;
  localparam int unsigned HistSize = HISTORY_DEPTH * LINE_SIZE;

  logic [7:0]    line_mem [LINE_SIZE];
  logic [7:0]    hist_mem [HistSize];
  logic [LW-1:0] hlen_q   [HISTORY_DEPTH];

  logic [LW-1:0] len_q, cur_q, idx_q;
  logic [HW-1:0] head_q, slot_q, pos_q;
  logic [CW-1:0] cnt_q;
  logic          recalled_q;
  logic [7:0]    char_q, line_rd_q, hist_rd_q;
  logic          out_valid_q, out_last_q;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_char_q;

  logic          out_free;
  logic [CW-1:0] nxt_pos;
  logic [HW-1:0] wslot;
  logic          line_we;
  logic [LW-1:0] line_wa, line_ra;
  logic [7:0]    line_wd;
  logic [AW-1:0] hist_addr;

  // slot of the entry k steps older than the head
  function automatic logic [HW-1:0] slot_back(input logic [HW-1:0] h, input logic [HW-1:0] k);
    logic [HW:0] s;
    s = {1'b0, h} + (HW+1)'(HISTORY_DEPTH) - {1'b0, k};
    if (s >= (HW+1)'(HISTORY_DEPTH)) s = s - (HW+1)'(HISTORY_DEPTH);
    return s[HW-1:0];
  endfunction

  assign out_free = !out_valid_q || !ev_stall_i;
  assign nxt_pos  = recalled_q ? CW'(pos_q) + CW'(1) : '0;
  assign wslot    = (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + HW'(1);

  // status
  assign stat_o.len_zero    = (len_q == '0);
  assign stat_o.cur_zero    = (cur_q == '0);
  assign stat_o.full        = (len_q >= LW'(LineCap));
  assign stat_o.idx_gt_cur  = (idx_q > cur_q);
  assign stat_o.idx_lt_len  = (idx_q < len_q);
  assign stat_o.idx_last    = (({1'b0, idx_q} + (LW+1)'(1)) == {1'b0, len_q});
  assign stat_o.idx_lt_hlen = (idx_q < hlen_q[slot_q]);
  assign stat_o.older_ok    = (nxt_pos < cnt_q);
  assign stat_o.recalled    = recalled_q;
  assign stat_o.pos_zero    = (pos_q == '0);
  assign stat_o.out_free    = out_free;

  // line memory port selection
  always_comb begin
    line_we = 1'b0;
    line_wa = idx_q;
    line_wd = line_rd_q;
    line_ra = idx_q;
    unique case (op_i)
      OpInsRd:  line_ra = idx_q - LW'(1);
      OpInsWr:  line_we = 1'b1;
      OpInsFin: begin
        line_we = 1'b1;
        line_wa = cur_q;
        line_wd = char_q;
      end
      OpDelWr: begin
        line_we = 1'b1;
        line_wa = idx_q - LW'(1);
      end
      OpLoadWr: begin
        line_we = 1'b1;
        line_wd = hist_rd_q;
      end
      default: line_we = 1'b0;
    endcase
  end

  assign hist_addr = AW'(slot_q) * AW'(LINE_SIZE) + AW'(idx_q);

  // line memory
  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_wa] <= line_wd;
    line_rd_q <= line_mem[line_ra];
  end

  // history memory, one row per slot
  always_ff @(posedge clk_i) begin
    if (op_i == OpEntOut) hist_mem[hist_addr] <= line_rd_q;
    hist_rd_q <= hist_mem[hist_addr];
  end

  // held byte for an insert
  always_ff @(posedge clk_i) begin
    if (op_i == OpInsStart) char_q <= rx_byte_i;
  end

  // line, cursor and history control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      cur_q      <= '0;
      idx_q      <= '0;
      head_q     <= '0;
      slot_q     <= '0;
      pos_q      <= '0;
      cnt_q      <= '0;
      recalled_q <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hlen_q[i] <= '0;
    end else begin
      unique case (op_i)
        OpHome:  cur_q <= '0;
        OpEnd:   cur_q <= len_q;
        OpRight: if (cur_q < len_q) cur_q <= cur_q + LW'(1);
        OpLeft:  if (cur_q != '0) cur_q <= cur_q - LW'(1);
        OpAbortOut, OpEmptyOut, OpNewerClr: begin
          len_q      <= '0;
          cur_q      <= '0;
          recalled_q <= 1'b0;
        end
        OpInsStart: idx_q <= len_q;
        OpInsWr:    idx_q <= idx_q - LW'(1);
        OpInsFin: begin
          len_q <= len_q + LW'(1);
          cur_q <= cur_q + LW'(1);
        end
        OpDelStart: idx_q <= cur_q;
        OpDelWr:    idx_q <= idx_q + LW'(1);
        OpDelFin: begin
          len_q <= len_q - LW'(1);
          cur_q <= cur_q - LW'(1);
        end
        OpEntStart: begin
          idx_q  <= '0;
          slot_q <= wslot;
        end
        OpEntOut: idx_q <= idx_q + LW'(1);
        OpEntFin: begin
          head_q         <= slot_q;
          hlen_q[slot_q] <= len_q;
          if (cnt_q < CW'(HISTORY_DEPTH)) cnt_q <= cnt_q + CW'(1);
          len_q      <= '0;
          cur_q      <= '0;
          recalled_q <= 1'b0;
        end
        OpOlder: begin
          pos_q      <= nxt_pos[HW-1:0];
          recalled_q <= 1'b1;
          slot_q     <= slot_back(head_q, nxt_pos[HW-1:0]);
          idx_q      <= '0;
        end
        OpNewer: begin
          pos_q  <= pos_q - HW'(1);
          slot_q <= slot_back(head_q, pos_q - HW'(1));
          idx_q  <= '0;
        end
        OpLoadWr: idx_q <= idx_q + LW'(1);
        OpLoadFin: begin
          len_q <= hlen_q[slot_q];
          cur_q <= hlen_q[slot_q];
        end
        default: idx_q <= idx_q;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OpAbortOut || op_i == OpEmptyOut || op_i == OpEntOut) begin
      out_valid_q <= 1'b1;
    end else if (!ev_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OpAbortOut: begin
        out_kind_q <= EvAbort;
        out_char_q <= '0;
        out_last_q <= 1'b1;
      end
      OpEmptyOut: begin
        out_kind_q <= EvEmpty;
        out_char_q <= '0;
        out_last_q <= 1'b1;
      end
      OpEntOut: begin
        out_kind_q <= EvChar;
        out_char_q <= line_rd_q;
        out_last_q <= stat_o.idx_last;
      end
      default: out_kind_q <= out_kind_q;
    endcase
  end

  assign ev_valid_o     = out_valid_q;
  assign event_kind_o   = out_kind_q;
  assign line_char_o    = out_char_q;
  assign last_of_line_o = out_last_q;

endmodule

// ----- rtl/terminal_line_editor_unit.sv -----
// top level of the terminal line editor with history
//
//  channel | direction | handshake            | payload
//  rx      | in        | rx_valid_i/rx_stall_o | rx_byte_i
//  ev      | out       | ev_valid_o/ev_stall_i | event_kind_o, line_char_o, last_of_line_o
//
// cursor moves, escape bytes and ignored bytes are handled in idle; abort and empty line wait
// in their own state for a free result register. insert and delete shift each character with a
// read state then a write state, as the line memory read is registered; history recall alike.
// enter reads and sends each character in turn and waits while ev_stall_i holds the result.
// rst_ni clears line, cursor, decoder and history lengths at once; no clearing pass.
// rx_stall_o is high while a request is in progress outside the idle state.
module terminal_line_editor_unit import tle_pkg::*; #(
  parameter int unsigned LINE_SIZE     = LineSizeDef,
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       ev_valid_o,
  input  logic       ev_stall_i,
  output logic [1:0] event_kind_o,
  output logic [7:0] line_char_o,
  output logic       last_of_line_o
);

  dp_op_e   op;
  dp_stat_t stat;

  // sequencer
  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .rx_byte_i  (rx_byte_i),
    .stat_i     (stat),
    .op_o       (op)
  );

  // storage and result register
  tle_dp #(
    .LINE_SIZE     (LINE_SIZE),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .rx_byte_i      (rx_byte_i),
    .stat_o         (stat),
    .ev_valid_o     (ev_valid_o),
    .ev_stall_i     (ev_stall_i),
    .event_kind_o   (event_kind_o),
    .line_char_o    (line_char_o),
    .last_of_line_o (last_of_line_o)
  );

endmodule

// ----- tb/terminal_line_editor_unit_test.sv -----
// self-checking testbench of the terminal line editor: directed table then random keystrokes
module terminal_line_editor_unit_test;
  import tle_pkg::*;

  localparam int unsigned LineCap   = (LineSizeDef - 1 < 63) ? LineSizeDef - 1 : 63;
  localparam int unsigned HistDepth = HistoryDepthDef;
  localparam int unsigned RandItems = 370;
  localparam longint      CycleLimit = 4000000;

  // result record
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } line_event_t;

  // directed row: byte, and a typed result where it is obvious
  typedef struct {
    logic [7:0]  rx;
    bit          fixed;
    line_event_t ev;
  } key_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       rx_valid_i;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i;
  logic       ev_valid_o;
  logic       ev_stall_i;
  logic [1:0] event_kind_o;
  logic [7:0] line_char_o;
  logic       last_of_line_o;

  terminal_line_editor_unit uut (
    .clk_i, .rst_ni, .rx_valid_i, .rx_stall_o, .rx_byte_i,
    .ev_valid_o, .ev_stall_i, .event_kind_o, .line_char_o, .last_of_line_o
  );

  // editor shadow state
  logic [7:0]  ed_line [LineCap];
  int unsigned ed_len, ed_cur, ed_phase;
  logic [7:0]  ed_hist [HistDepth][LineCap];
  int unsigned ed_hlen [HistDepth];
  int unsigned ed_hcount, ed_hpos;
  bit          ed_recalled;

  line_event_t pending_events[$];
  int          error_count;
  longint      cycle_count;
  bit          idle_free;
  bit          hold_rx_stall;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic void clear_edit();
    ed_len = 0; ed_cur = 0; ed_phase = 0; ed_recalled = 0;
  endfunction

  function automatic void load_hist(int unsigned k);
    for (int i = 0; i < ed_hlen[k]; i++) ed_line[i] = ed_hist[k][i];
    ed_len = ed_hlen[k];
    ed_cur = ed_len;
  endfunction

  // predict the results of one byte and queue them
  function automatic void predict_key(logic [7:0] c);
    int unsigned ph;
    line_event_t e;
    if (c == ByteCtrlC || c == ByteCtrlD) begin
      clear_edit();
      e = '{EvAbort, 8'd0, 1'b1}; pending_events.push_back(e);
      return;
    end
    if (c == ByteCtrlA) begin ed_cur = 0; return; end
    if (c == ByteCtrlE) begin ed_cur = ed_len; return; end
    if (c == ByteDel) begin
      if (ed_cur != 0) begin
        for (int i = ed_cur; i < ed_len; i++) ed_line[i-1] = ed_line[i];
        ed_cur--; ed_len--;
      end
      return;
    end
    if (c == ByteEsc) begin ed_phase = 1; return; end
    ph = ed_phase;
    if (ph != 0) begin
      ed_phase = 0;
      if (ph == 1) begin
        if (c == ByteCsi) ed_phase = 2;
        else if (c == ByteSs3) ed_phase = 3;
      end else if (ph == 2) begin
        if (c == ByteUp) begin
          int unsigned nx;
          nx = ed_recalled ? ed_hpos + 1 : 0;
          if (nx < ed_hcount) begin
            ed_hpos = nx; ed_recalled = 1; load_hist(nx);
          end
        end else if (c == ByteDown) begin
          if (ed_recalled) begin
            if (ed_hpos == 0) begin
              ed_recalled = 0; ed_len = 0; ed_cur = 0;
            end else begin
              ed_hpos--; load_hist(ed_hpos);
            end
          end
        end else if (c == ByteRight) begin
          if (ed_cur < ed_len) ed_cur++;
        end else if (c == ByteLeft) begin
          if (ed_cur > 0) ed_cur--;
        end
      end else begin
        if (c == ByteHome) ed_cur = 0;
        else if (c == ByteEnd) ed_cur = ed_len;
      end
      return;
    end
    if (c == ByteEnter) begin
      if (ed_len == 0) begin
        e = '{EvEmpty, 8'd0, 1'b1}; pending_events.push_back(e);
      end else begin
        for (int i = 0; i < ed_len; i++) begin
          e = '{EvChar, ed_line[i], (i + 1 == ed_len)}; pending_events.push_back(e);
        end
        for (int k = HistDepth - 1; k > 0; k--) begin
          ed_hist[k] = ed_hist[k-1]; ed_hlen[k] = ed_hlen[k-1];
        end
        for (int i = 0; i < ed_len; i++) ed_hist[0][i] = ed_line[i];
        ed_hlen[0] = ed_len;
        if (ed_hcount < HistDepth) ed_hcount++;
      end
      clear_edit();
      return;
    end
    if (c >= BytePrtLo && c <= BytePrtHi && ed_len < LineCap) begin
      for (int i = ed_len; i > ed_cur; i--) ed_line[i] = ed_line[i-1];
      ed_line[ed_cur] = c;
      ed_len++; ed_cur++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    line_event_t want;
    if (rst_ni && ev_valid_o && !ev_stall_i) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        want = pending_events.pop_front();
        if (event_kind_o !== want.kind)
          report_mismatch($sformatf("kind %0d want %0d", event_kind_o, want.kind));
        if (line_char_o !== want.ch)
          report_mismatch($sformatf("char %0d want %0d", line_char_o, want.ch));
        if (last_of_line_o !== want.last)
          report_mismatch($sformatf("last %0d want %0d", last_of_line_o, want.last));
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    ev_stall_i <= (!idle_free && $urandom_range(99) < 7) || hold_rx_stall;
  end

  // send one request, checking a typed result when given; valid stays up afterwards
  task automatic send_key(input logic [7:0] c, input bit fixed, input line_event_t ev);
    int queued;
    while (!idle_free && $urandom_range(99) < 7) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= c;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    queued = pending_events.size();
    predict_key(c);
    if (fixed && (pending_events.size() != queued + 1 || pending_events[queued] != ev))
      report_mismatch($sformatf("typed row for byte %0d disagrees", c));
    @(negedge clk_i);
  endtask

  task automatic drain_events();
    rx_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  // random printable byte
  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(BytePrtHi, BytePrtLo));
  endfunction

  initial begin
    key_row_t rows[$];
    line_event_t none;
    logic [7:0] c;
    int sent, r;
    none = '0;
    rst_ni = 1'b0; rx_valid_i = 1'b0; rx_byte_i = '0; ev_stall_i = 1'b0;
    error_count = 0; cycle_count = 0; idle_free = 0; hold_rx_stall = 0;
    clear_edit(); ed_hcount = 0; ed_hpos = 0;
    for (int k = 0; k < HistDepth; k++) ed_hlen[k] = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    rows.push_back('{ByteEnter, 1, '{EvEmpty, 8'd0, 1'b1}});
    rows.push_back('{8'd32, 0, none});
    rows.push_back('{8'd126, 0, none});
    rows.push_back('{ByteCtrlA, 0, none});
    rows.push_back('{8'd65, 0, none});
    rows.push_back('{ByteDel, 0, none});
    rows.push_back('{ByteDel, 0, none});
    rows.push_back('{ByteCtrlE, 0, none});
    rows.push_back('{ByteEsc, 0, none});
    rows.push_back('{ByteCsi, 0, none});
    rows.push_back('{ByteLeft, 0, none});
    rows.push_back('{8'd0, 0, none});
    rows.push_back('{8'd255, 0, none});
    rows.push_back('{8'd128, 0, none});
    rows.push_back('{ByteEnter, 0, none});
    rows.push_back('{ByteEsc, 0, none});
    rows.push_back('{ByteCsi, 0, none});
    rows.push_back('{ByteUp, 0, none});
    rows.push_back('{ByteEsc, 0, none});
    rows.push_back('{ByteSs3, 0, none});
    rows.push_back('{ByteHome, 0, none});
    rows.push_back('{ByteEsc, 0, none});
    rows.push_back('{ByteCtrlC, 1, '{EvAbort, 8'd0, 1'b1}});
    rows.push_back('{ByteCtrlD, 1, '{EvAbort, 8'd0, 1'b1}});
    foreach (rows[i]) send_key(rows[i].rx, rows[i].fixed, rows[i].ev);

    // full line: fill past capacity, try an insert at home (refused, line full), enter
    for (int i = 0; i < 66; i++) send_key(rand_print(), 0, none);
    send_key(ByteCtrlA, 0, none);
    send_key(8'd90, 0, none);
    send_key(ByteEnter, 0, none);

    // sender holds while the receiver is held stalled, then until all results are out
    rx_valid_i <= 1'b0;
    hold_rx_stall = 1;
    repeat (50) @(negedge clk_i);
    hold_rx_stall = 0;
    drain_events();

    // random part, mostly well-formed editing with noise
    sent = 0;
    while (sent < RandItems) begin
      idle_free = (sent >= 150 && sent < 230);
      r = $urandom_range(99);
      if (r < 45) begin
        c = rand_print(); send_key(c, 0, none); sent++;
      end else if (r < 60) begin
        send_key(ByteEsc, 0, none);
        send_key(($urandom_range(1)) ? ByteCsi : ByteSs3, 0, none);
        case ($urandom_range(7))
          0: c = ByteUp;
          1: c = ByteDown;
          2: c = ByteRight;
          3: c = ByteLeft;
          4: c = ByteHome;
          5: c = ByteEnd;
          6: c = ByteEnter;
          default: c = 8'($urandom);
        endcase
        send_key(c, 0, none); sent += 3;
      end else if (r < 70) begin
        send_key(ByteDel, 0, none); sent++;
      end else if (r < 78) begin
        send_key(ByteEnter, 0, none); sent++;
      end else if (r < 84) begin
        send_key(($urandom_range(1)) ? ByteCtrlA : ByteCtrlE, 0, none); sent++;
      end else if (r < 87) begin
        send_key(($urandom_range(1)) ? ByteCtrlC : ByteCtrlD, 0, none); sent++;
      end else if (r < 90) begin
        send_key(ByteEsc, 0, none); sent++;
      end else begin
        send_key(8'($urandom), 0, none); sent++;
      end
    end
    idle_free = 0;
    send_key(ByteEnter, 0, none);

    drain_events();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- terminal_line_editor_unit.f -----
rtl/tle_pkg.sv
rtl/tle_ctrl.sv
rtl/tle_dp.sv
rtl/terminal_line_editor_unit.sv
tb/terminal_line_editor_unit_test.sv
